[sv/hilbert_tile_order_mapper_top_defines.svh]
// ---------------------------------------------------------------------------
// Hilbert tile order mapper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HILBERT_TILE_ORDER_MAPPER_TOP_DEFINES_SVH
`define HILBERT_TILE_ORDER_MAPPER_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define HTO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define HTO_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/hto_pkg.sv]
// ---------------------------------------------------------------------------
// Hilbert tile order mapper package
// Widths, constants, shared types and helper functions of the mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package hto_pkg;

  localparam int TILE_SIZE = 48;
  localparam int MAX_ORDER = 8;

  localparam int DIM_W   = 14;
  localparam int IDX_W   = 16;
  localparam int GRID_W  = 8;
  localparam int SIZE_W  = 6;
  localparam int COUNT_W = 9;
  localparam int ORDER_W = 4;
  localparam int CFG_IDX_W = 1;

  // A tile of 48 pixels is 16 times 3: shift by 4, then multiply by a
  // reciprocal of 3 that is exact for every quotient below 2048.
  localparam int TILE_POW2_SH = 4;
  localparam int TILE_ODD_MUL = 683;
  localparam int TILE_ODD_SH  = 11;
  localparam int PROD_W       = 21;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(1080);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_w;
    logic [DIM_W-1:0]   frame_h;
    logic [COUNT_W-1:0] cols;
    logic [COUNT_W-1:0] rows;
    logic [ORDER_W-1:0] order;
  } grid_cfg_t;

  typedef struct packed {
    logic              beyond;
    logic [GRID_W-1:0] gx;
    logic [GRID_W-1:0] gy;
  } decode_t;

  typedef struct packed {
    logic              in_frame;
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic [DIM_W-1:0]  tile_x;
    logic [DIM_W-1:0]  tile_y;
    logic [SIZE_W-1:0] tile_w;
    logic [SIZE_W-1:0] tile_h;
  } result_t;

  function automatic logic [COUNT_W-1:0] tiles_for(input logic [DIM_W-1:0] pixels);
    logic [DIM_W:0]    sum;
    logic [DIM_W:0]    q16;
    logic [PROD_W-1:0] prod;
    sum  = {1'b0, pixels} + (DIM_W+1)'(TILE_SIZE - 1);
    q16  = sum >> TILE_POW2_SH;
    prod = PROD_W'(q16) * PROD_W'(TILE_ODD_MUL);
    return COUNT_W'(prod >> TILE_ODD_SH);
  endfunction

  function automatic logic [ORDER_W-1:0] curve_order(input logic [COUNT_W-1:0] side);
    logic [ORDER_W-1:0] o;
    o = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (side > (COUNT_W'(1) << i)) begin
        o = ORDER_W'(i + 1);
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[sv/hto_if.sv]
// ---------------------------------------------------------------------------
// Hilbert tile order mapper channels
// Valid/ready interfaces for index requests, tile results and config writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface hto_in_if;
  import hto_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] curve_index;
  modport source (output valid, output curve_index, input ready);
  modport sink (input valid, input curve_index, output ready);
endinterface

interface hto_out_if;
  import hto_pkg::*;
  logic              valid;
  logic              ready;
  logic              in_frame;
  logic [GRID_W-1:0] grid_x;
  logic [GRID_W-1:0] grid_y;
  logic [DIM_W-1:0]  tile_x;
  logic [DIM_W-1:0]  tile_y;
  logic [SIZE_W-1:0] tile_w;
  logic [SIZE_W-1:0] tile_h;
  modport source (output valid, output in_frame, output grid_x, output grid_y,
                  output tile_x, output tile_y, output tile_w, output tile_h,
                  input ready);
  modport sink (input valid, input in_frame, input grid_x, input grid_y,
                input tile_x, input tile_y, input tile_w, input tile_h,
                output ready);
endinterface

interface hto_cfg_if;
  import hto_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/hto_grid_cfg.sv]
// ---------------------------------------------------------------------------
// Hilbert tile order mapper grid configuration
// Frame size registers, tile grid size and curve order.
// ---------------------------------------------------------------------------
`default_nettype none

module hto_grid_cfg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  hto_cfg_if.sink             cfg_ch,
  output hto_pkg::grid_cfg_t  grid
);
  import hto_pkg::*;

  logic [DIM_W-1:0]   frame_w_r, frame_w_nxt;
  logic [DIM_W-1:0]   frame_h_r, frame_h_nxt;
  logic [COUNT_W-1:0] cols_r, cols_nxt;
  logic [COUNT_W-1:0] rows_r, rows_nxt;
  logic [COUNT_W-1:0] side;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    frame_w_nxt = frame_w_r;
    frame_h_nxt = frame_h_r;
    cols_nxt    = cols_r;
    rows_nxt    = rows_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FRAME_WIDTH: begin
          frame_w_nxt = cfg_ch.data;
          cols_nxt    = tiles_for(cfg_ch.data);
        end
        CFG_FRAME_HEIGHT: begin
          frame_h_nxt = cfg_ch.data;
          rows_nxt    = tiles_for(cfg_ch.data);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_WIDTH_RST;
      frame_h_r <= FRAME_HEIGHT_RST;
      cols_r    <= tiles_for(FRAME_WIDTH_RST);
      rows_r    <= tiles_for(FRAME_HEIGHT_RST);
    end else begin
      frame_w_r <= frame_w_nxt;
      frame_h_r <= frame_h_nxt;
      cols_r    <= cols_nxt;
      rows_r    <= rows_nxt;
    end
  end

  assign side = (cols_r > rows_r) ? cols_r : rows_r;

  assign grid.frame_w = frame_w_r;
  assign grid.frame_h = frame_h_r;
  assign grid.cols    = cols_r;
  assign grid.rows    = rows_r;
  assign grid.order   = curve_order(side);

endmodule

`default_nettype wire

[sv/hto_hilbert_decode.sv]
// ---------------------------------------------------------------------------
// Hilbert tile order mapper curve decoder
// Turns a curve index into a grid column and row, one level per step.
// ---------------------------------------------------------------------------
`default_nettype none

module hto_hilbert_decode (
  input  wire logic [hto_pkg::IDX_W-1:0]   curve_index,
  input  wire logic [hto_pkg::ORDER_W-1:0] order,
  output hto_pkg::decode_t                 dec
);
  import hto_pkg::*;

  logic [GRID_W-1:0] gx, gy;

  always_comb begin
    logic [GRID_W-1:0] s;
    logic [GRID_W-1:0] tmp;
    logic              rx;
    logic              ry;
    gx = '0;
    gy = '0;
    for (int lvl = 0; lvl < MAX_ORDER; lvl++) begin
      s   = GRID_W'(1) << lvl;
      rx  = curve_index[2*lvl+1];
      ry  = curve_index[2*lvl] ^ rx;
      tmp = gx;
      if (lvl < int'(order)) begin
        if (!ry) begin
          if (rx) begin
            gx = s - GRID_W'(1) - gx;
            gy = s - GRID_W'(1) - gy;
          end
          tmp = gx;
          gx  = gy;
          gy  = tmp;
        end
        if (rx) begin
          gx = gx | s;
        end
        if (ry) begin
          gy = gy | s;
        end
      end
    end
  end

  assign dec.beyond = (curve_index >> {order, 1'b0}) != '0;
  assign dec.gx     = gx;
  assign dec.gy     = gy;

endmodule

`default_nettype wire

[sv/hto_tile_geom.sv]
// ---------------------------------------------------------------------------
// Hilbert tile order mapper tile geometry
// Frame test, pixel origin and clipped size of a decoded tile.
// ---------------------------------------------------------------------------
`default_nettype none

module hto_tile_geom (
  input  wire hto_pkg::decode_t   dec,
  input  wire hto_pkg::grid_cfg_t grid,
  output hto_pkg::result_t        res
);
  import hto_pkg::*;

  logic              in_grid;
  logic [DIM_W-1:0]  px, py;
  logic [DIM_W-1:0]  rem_x, rem_y;
  logic [SIZE_W-1:0] tw, th;

  assign in_grid = ({1'b0, dec.gx} < grid.cols) && ({1'b0, dec.gy} < grid.rows);
  assign px      = DIM_W'(dec.gx) * DIM_W'(TILE_SIZE);
  assign py      = DIM_W'(dec.gy) * DIM_W'(TILE_SIZE);
  assign rem_x   = grid.frame_w - px;
  assign rem_y   = grid.frame_h - py;
  assign tw      = (rem_x < DIM_W'(TILE_SIZE)) ? rem_x[SIZE_W-1:0] : SIZE_W'(TILE_SIZE);
  assign th      = (rem_y < DIM_W'(TILE_SIZE)) ? rem_y[SIZE_W-1:0] : SIZE_W'(TILE_SIZE);

  always_comb begin
    res = '0;
    if (!dec.beyond) begin
      res.in_frame = in_grid;
      res.grid_x   = dec.gx;
      res.grid_y   = dec.gy;
      res.tile_x   = px;
      res.tile_y   = py;
      res.tile_w   = in_grid ? tw : '0;
      res.tile_h   = in_grid ? th : '0;
    end
  end

endmodule

`default_nettype wire

[sv/hilbert_tile_order_mapper_top.sv]
// ---------------------------------------------------------------------------
// Hilbert tile order mapper
// Maps a Hilbert curve index to a 48-pixel render tile of the frame.
// ---------------------------------------------------------------------------
// The mapper takes one curve index request per clock while the result side
// does not stall and returns one tile result per request, in order, through
// the index register and the result register. The rate is set by the single
// registered decode pass between them; the result register lets a new request
// enter while a finished result waits. Frame size writes are always ready and
// apply to each request that enters the result register after the write.
`default_nettype none
`include "hilbert_tile_order_mapper_top_defines.svh"

module hilbert_tile_order_mapper_top (
  input  wire logic clk,
  input  wire logic rst_n,
  hto_in_if.sink    in_ch,
  hto_out_if.source out_ch,
  hto_cfg_if.sink   cfg_ch
);
  import hto_pkg::*;

  grid_cfg_t        grid;
  decode_t          dec;
  result_t          res;
  logic             s1_valid_r, s1_valid_nxt;
  logic [IDX_W-1:0] s1_idx_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_data_r;
  logic             s2_take;

  hto_grid_cfg u_grid_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .grid   (grid)
  );

  hto_hilbert_decode u_decode (
    .curve_index (s1_idx_r),
    .order       (grid.order),
    .dec         (dec)
  );

  hto_tile_geom u_geom (
    .dec  (dec),
    .grid (grid),
    .res  (res)
  );

  assign s2_take     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s2_take;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    if (s2_take) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_idx_r <= in_ch.curve_index;
    end
    if (s2_take && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.in_frame = out_data_r.in_frame;
  assign out_ch.grid_x   = out_data_r.grid_x;
  assign out_ch.grid_y   = out_data_r.grid_y;
  assign out_ch.tile_x   = out_data_r.tile_x;
  assign out_ch.tile_y   = out_data_r.tile_y;
  assign out_ch.tile_w   = out_data_r.tile_w;
  assign out_ch.tile_h   = out_data_r.tile_h;

  `HTO_ASSERT(a_frame_size, out_ch.valid |-> (out_ch.in_frame == ((out_ch.tile_w != '0) && (out_ch.tile_h != '0))), "tile size disagrees with frame flag")
  `HTO_ASSERT(a_origin, out_ch.valid |-> (out_ch.tile_x == DIM_W'(out_ch.grid_x) * DIM_W'(TILE_SIZE)), "tile origin disagrees with grid column")
  `HTO_ASSERT_NEXT(a_advance, s1_valid_r && s2_take, out_valid_r, "decoded request was not moved to the result register")

endmodule

`default_nettype wire
